// ----- hw/rtl/csat_pkg.sv -----
// shared constants and types of the circle / shape axis overlap test
package csat_pkg;

	// default coordinate width, signed Q16.8
	localparam int COORD_BITS_DEF = 24;

	// number of pipeline stages from input register to output register
	localparam int NUM_STAGES = 8;

	// shape kind carried in the input tuser
	typedef enum logic [1:0] {
		KIND_CIRCLE = 2'd0,
		KIND_RECT   = 2'd1,
		KIND_TRI    = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// per-item flags that travel beside the triangle lanes
	typedef struct packed {
		logic keep;    // circle / rectangle result, or 1 for a triangle
		logic is_tri;  // item is a triangle, lane results apply
	} side_t;

endpackage

// ----- hw/rtl/circle_shape_axis_overlap_test_unit.sv -----
// Circle versus shape overlap test by separating axes, eight-stage pipeline.
// One item enters per clock cycle when the output side keeps up; each item
// yields exactly one result, produced through
// eight register stages set by the triangle path (input, edge products,
// projections, interval, gap, split squares, squared sum, compare). Each
// stage holds its item while the next is full,
// so bubbles close up under a stalled output and s_tready stays high as
// long as any stage is empty. Action 3 names no shape and gives hit 0.
module circle_shape_axis_overlap_test_unit #(
	parameter int COORD_BITS = csat_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// circle_x, circle_y, circle_radius, shape_radius, shape_a_x, shape_a_y,
	// shape_b_x, shape_b_y, shape_c_x, shape_c_y, zero fill
	input  logic [((10*COORD_BITS-2+7)/8)*8-1:0]  s_tdata,
	// action
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// hit, zero fill
	output logic [7:0]                            m_tdata
);
	import csat_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int NS = NUM_STAGES;

	logic [NS:1] v_q;
	logic [NS:1] rdy;

	side_t                side_s1;
	side_t                side_s [2:7];
	logic signed [C-1:0]  vx_s1 [0:3];
	logic signed [C-1:0]  vy_s1 [0:3];
	logic signed [C:0]    dx_s1 [0:2];
	logic signed [C:0]    dy_s1 [0:2];
	logic        [C-2:0]  rad_s1;
	logic        [2:0]    sep;
	logic                 hit_s8;

	// stage ready: a stage takes a new item when empty or when it moves on
	always_comb begin
		rdy[NS] = !v_q[NS] || m_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = v_q[NS];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// input stage
	csat_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (rdy[1]),
		.kind         (kind_t'(s_tuser)),
		.circle_x     ($signed(s_tdata[C-1:0])),
		.circle_y     ($signed(s_tdata[2*C-1:C])),
		.circle_radius(s_tdata[3*C-2:2*C]),
		.shape_radius (s_tdata[4*C-3:3*C-1]),
		.shape_a_x    ($signed(s_tdata[5*C-3:4*C-2])),
		.shape_a_y    ($signed(s_tdata[6*C-3:5*C-2])),
		.shape_b_x    ($signed(s_tdata[7*C-3:6*C-2])),
		.shape_b_y    ($signed(s_tdata[8*C-3:7*C-2])),
		.shape_c_x    ($signed(s_tdata[9*C-3:8*C-2])),
		.shape_c_y    ($signed(s_tdata[10*C-3:9*C-2])),
		.side_s1      (side_s1),
		.vx_s1        (vx_s1),
		.vy_s1        (vy_s1),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1),
		.rad_s1       (rad_s1)
	);

	// one lane per triangle edge
	for (genvar g = 0; g < 3; g++) begin : g_lane
		csat_edge_lane #(
			.COORD_BITS(COORD_BITS)
		) u_lane (
			.clk   (clk),
			.en    (rdy[7:2]),
			.vx_s1 (vx_s1),
			.vy_s1 (vy_s1),
			.dx_s1 (dx_s1[g]),
			.dy_s1 (dy_s1[g]),
			.rad_s1(rad_s1),
			.sep   (sep[g])
		);
	end

	// side flags delayed alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= 7; k++) begin
				side_s[k] <= '{keep: 1'b0, is_tri: 1'b0};
			end
		end else begin
			if (rdy[2]) begin
				side_s[2] <= side_s1;
			end
			for (int k = 3; k <= 7; k++) begin
				if (rdy[k]) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// output stage: combine kind result with edge separations
	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			hit_s8 <= side_s[7].keep && !(side_s[7].is_tri && (sep != '0));
		end
	end

	assign m_tdata = {7'b0, hit_s8};

endmodule

// ----- hw/rtl/csat_front.sv -----
// input stage: circle and rectangle interval tests, triangle edge vectors
module csat_front #(
	parameter int COORD_BITS = csat_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  csat_pkg::kind_t                kind,
	input  logic signed [COORD_BITS-1:0]   circle_x,
	input  logic signed [COORD_BITS-1:0]   circle_y,
	input  logic        [COORD_BITS-2:0]   circle_radius,
	input  logic        [COORD_BITS-2:0]   shape_radius,
	input  logic signed [COORD_BITS-1:0]   shape_a_x,
	input  logic signed [COORD_BITS-1:0]   shape_a_y,
	input  logic signed [COORD_BITS-1:0]   shape_b_x,
	input  logic signed [COORD_BITS-1:0]   shape_b_y,
	input  logic signed [COORD_BITS-1:0]   shape_c_x,
	input  logic signed [COORD_BITS-1:0]   shape_c_y,
	output csat_pkg::side_t                side_s1,
	output logic signed [COORD_BITS-1:0]   vx_s1 [0:3],
	output logic signed [COORD_BITS-1:0]   vy_s1 [0:3],
	output logic signed [COORD_BITS:0]     dx_s1 [0:2],
	output logic signed [COORD_BITS:0]     dy_s1 [0:2],
	output logic        [COORD_BITS-2:0]   rad_s1
);
	import csat_pkg::*;

	localparam int WW = COORD_BITS + 2;

	logic signed [WW-1:0] cx, cy, ax, ay, bx, by, r, sr;
	logic signed [WW-1:0] xlo, xhi, ylo, yhi;
	logic                 circ_hit, rect_x_ok, rect_y_ok;
	side_t                side;

	// widen operands so no sum can wrap
	always_comb begin
		cx = WW'(circle_x);
		cy = WW'(circle_y);
		ax = WW'(shape_a_x);
		ay = WW'(shape_a_y);
		bx = WW'(shape_b_x);
		by = WW'(shape_b_y);
		r  = $signed({3'b000, circle_radius});
		sr = $signed({3'b000, shape_radius});
	end

	// circle pair: overlap on both unit axis pairs
	assign circ_hit = (cx - ax <= r + sr) && (ax - cx <= r + sr) &&
		(cy - ay <= r + sr) && (ay - cy <= r + sr);

	// rectangle extents, negative sizes flip the span
	always_comb begin
		xlo = bx[WW-1] ? ax + bx : ax;
		xhi = bx[WW-1] ? ax : ax + bx;
		ylo = by[WW-1] ? ay + by : ay;
		yhi = by[WW-1] ? ay : ay + by;
	end

	// a zero side gives a zero axis that never separates
	assign rect_x_ok = (shape_b_x == '0) || ((cx + r >= xlo) && (xhi >= cx - r));
	assign rect_y_ok = (shape_b_y == '0) || ((cy + r >= ylo) && (yhi >= cy - r));

	// per-kind flags
	always_comb begin
		unique case (kind)
			KIND_CIRCLE: side = '{keep: circ_hit, is_tri: 1'b0};
			KIND_RECT:   side = '{keep: rect_x_ok && rect_y_ok, is_tri: 1'b0};
			KIND_TRI:    side = '{keep: 1'b1, is_tri: 1'b1};
			default:     side = '{keep: 1'b0, is_tri: 1'b0};
		endcase
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '{keep: 1'b0, is_tri: 1'b0};
		end else if (en) begin
			side_s1 <= side;
		end
	end

	// vertices (index 3 is the circle center), edge vectors, radius
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1[0] <= shape_a_x;
			vy_s1[0] <= shape_a_y;
			vx_s1[1] <= shape_b_x;
			vy_s1[1] <= shape_b_y;
			vx_s1[2] <= shape_c_x;
			vy_s1[2] <= shape_c_y;
			vx_s1[3] <= circle_x;
			vy_s1[3] <= circle_y;
			dx_s1[0] <= (COORD_BITS+1)'(shape_b_x) - (COORD_BITS+1)'(shape_a_x);
			dy_s1[0] <= (COORD_BITS+1)'(shape_b_y) - (COORD_BITS+1)'(shape_a_y);
			dx_s1[1] <= (COORD_BITS+1)'(shape_c_x) - (COORD_BITS+1)'(shape_b_x);
			dy_s1[1] <= (COORD_BITS+1)'(shape_c_y) - (COORD_BITS+1)'(shape_b_y);
			dx_s1[2] <= (COORD_BITS+1)'(shape_a_x) - (COORD_BITS+1)'(shape_c_x);
			dy_s1[2] <= (COORD_BITS+1)'(shape_a_y) - (COORD_BITS+1)'(shape_c_y);
			rad_s1   <= circle_radius;
		end
	end

endmodule

// ----- hw/rtl/csat_edge_lane.sv -----
// one triangle edge axis: projections, interval gap and exact squared compare
module csat_edge_lane #(
	parameter int COORD_BITS = csat_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic [7:2]                     en,
	input  logic signed [COORD_BITS-1:0]   vx_s1 [0:3],
	input  logic signed [COORD_BITS-1:0]   vy_s1 [0:3],
	input  logic signed [COORD_BITS:0]     dx_s1,
	input  logic signed [COORD_BITS:0]     dy_s1,
	input  logic        [COORD_BITS-2:0]   rad_s1,
	output logic                           sep
);
	localparam int PW  = 2 * COORD_BITS + 2;  // projection
	localparam int RW  = 2 * COORD_BITS - 2;  // radius squared
	localparam int EW  = PW + 1;              // gap, odd width
	localparam int H   = (EW + 1) / 2;        // low split
	localparam int HL  = EW - H;              // high split, H - 1
	localparam int QW  = 2 * EW;              // squared terms

	logic signed [PW-1:0] px_s2 [0:3];
	logic signed [PW-1:0] py_s2 [0:3];
	logic signed [PW-1:0] dxx_s2, dyy_s2;
	logic        [RW-1:0] rsq_s2;

	logic signed [PW-1:0] proj_s3 [0:3];
	logic        [PW-1:0] d2_s3;
	logic        [RW-1:0] rsq_s3;

	logic signed [PW-1:0] tmin_s4, tmax_s4, c_s4;
	logic        [PW-1:0] d2_s4;
	logic        [RW-1:0] rsq_s4;

	logic        [EW-1:0] e_s5;
	logic                 cand_s5;
	logic        [PW-1:0] d2_s5;
	logic        [RW-1:0] rsq_s5;

	logic [2*H-1:0] ehh_s6, ehl_s6, ell_s6;
	logic [2*H-1:0] rhh_s6, rhl_s6, rlh_s6, rll_s6;
	logic           cand_s6;

	logic [QW-1:0] ee_s7, rr_s7;
	logic          cand_s7;

	logic signed [PW-1:0] m01, m012, x01, x012;
	logic                 lo, hi;
	logic signed [PW:0]   gap;
	logic [H-1:0]         eh, el, rh, rl, dh, dl;
	logic [EW-1:0]        rsq_x, d2_x;

	// stage 2: products of every point with the edge vector
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 4; i++) begin
				px_s2[i] <= vx_s1[i] * dx_s1;
				py_s2[i] <= vy_s1[i] * dy_s1;
			end
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			rsq_s2 <= rad_s1 * rad_s1;
		end
	end

	// stage 3: dot products and squared axis length
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 4; i++) begin
				proj_s3[i] <= px_s2[i] + py_s2[i];
			end
			d2_s3  <= $unsigned(dxx_s2) + $unsigned(dyy_s2);
			rsq_s3 <= rsq_s2;
		end
	end

	// stage 4: triangle interval on the axis
	always_comb begin
		m01  = (proj_s3[1] < proj_s3[0]) ? proj_s3[1] : proj_s3[0];
		m012 = (proj_s3[2] < m01) ? proj_s3[2] : m01;
		x01  = (proj_s3[0] < proj_s3[1]) ? proj_s3[1] : proj_s3[0];
		x012 = (x01 < proj_s3[2]) ? proj_s3[2] : x01;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			tmin_s4 <= m012;
			tmax_s4 <= x012;
			c_s4    <= proj_s3[3];
			d2_s4   <= d2_s3;
			rsq_s4  <= rsq_s3;
		end
	end

	// stage 5: gap between the center projection and the interval
	always_comb begin
		lo  = c_s4 < tmin_s4;
		hi  = tmax_s4 < c_s4;
		gap = lo ? ((PW+1)'(tmin_s4) - (PW+1)'(c_s4))
			: ((PW+1)'(c_s4) - (PW+1)'(tmax_s4));
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			e_s5    <= gap[EW-1:0];
			cand_s5 <= lo || hi;
			d2_s5   <= d2_s4;
			rsq_s5  <= rsq_s4;
		end
	end

	// stage 6: split squares into partial products
	always_comb begin
		rsq_x = EW'(rsq_s5);
		d2_x  = EW'(d2_s5);
		eh    = {1'b0, e_s5[EW-1:H]};
		el    = e_s5[H-1:0];
		rh    = {1'b0, rsq_x[EW-1:H]};
		rl    = rsq_x[H-1:0];
		dh    = {1'b0, d2_x[EW-1:H]};
		dl    = d2_x[H-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			ehh_s6  <= eh * eh;
			ehl_s6  <= eh * el;
			ell_s6  <= el * el;
			rhh_s6  <= rh * dh;
			rhl_s6  <= rh * dl;
			rlh_s6  <= rl * dh;
			rll_s6  <= rl * dl;
			cand_s6 <= cand_s5;
		end
	end

	// stage 7: assemble gap squared and radius squared times axis length squared
	always_ff @(posedge clk) begin
		if (en[7]) begin
			ee_s7 <= (QW'(ehh_s6) << (2 * H)) + (QW'(ehl_s6) << (H + 1)) + QW'(ell_s6);
			rr_s7 <= (QW'(rhh_s6) << (2 * H)) + ((QW'(rhl_s6) + QW'(rlh_s6)) << H)
				+ QW'(rll_s6);
			cand_s7 <= cand_s6;
		end
	end

	// axis separates when the gap exceeds the scaled radius
	assign sep = cand_s7 && (ee_s7 > rr_s7);

	// high split width is one bit short of the low split
	if (HL + 1 != H) begin : g_split_check
		$error("edge lane split widths disagree");
	end

endmodule
